FILE: hw/rtl/sjf_pkg.sv
// Shared types and constants for the shortest-job-first scheduler.
// No dependencies; sjf_core and the top level import this package.
`timescale 1ns / 1ps

package sjf_pkg;

  localparam int MAX_PROCS_DEF = 64;
  localparam int TIME_BITS_DEF = 16;

  localparam int IN_TIME_W  = 16;
  localparam int ID_W       = 7;
  localparam int OUT_TIME_W = 24;
  localparam int AVG_W      = 32;
  localparam int FRAC_W     = 8;

  localparam logic [OUT_TIME_W-1:0] TIME_MAX = '1;
  localparam logic [AVG_W-1:0]      AVG_MAX  = '1;

  typedef struct packed {
    logic [IN_TIME_W-1:0] arrival_time;
    logic [IN_TIME_W-1:0] burst_time;
    logic                 is_last;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]       process_id;
    logic [OUT_TIME_W-1:0] start_time;
    logic [OUT_TIME_W-1:0] wait_time;
    logic [OUT_TIME_W-1:0] turnaround_time;
    logic [AVG_W-1:0]      avg_wait;
    logic [AVG_W-1:0]      avg_turnaround;
    logic [AVG_W-1:0]      avg_ratio;
    logic                  last_result;
  } out_item_t;

endpackage

FILE: hw/rtl/sjf_div.sv
// Restoring divider, one quotient bit per cycle, shared by all divisions.
// Depends on sjf_pkg only through the common file set; no types used.
`timescale 1ns / 1ps

module sjf_div #(
  parameter int DVD_W = 40,
  parameter int DVS_W = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DVD_W-1:0] dividend,
  input  logic [DVS_W-1:0] divisor,
  output logic             done,
  output logic [DVD_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r;
  logic [DVS_W-1:0] rem_r;
  logic [DVS_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [DVS_W:0]   sh;
  logic             ge;
  logic [DVS_W:0]   diff;

  always_comb begin
    sh   = {rem_r, q_r[DVD_W-1]};
    ge   = (sh >= {1'b0, dvs_r});
    diff = sh - {1'b0, dvs_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DVD_W);
        q_r    <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
      end else if (busy_r) begin
        // For a nonzero divisor the remainder stays below it, so its low bits suffice.
        rem_r <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
        q_r   <= {q_r[DVD_W-2:0], ge};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule

FILE: hw/rtl/sjf_core.sv
// Process stores, scan sequencer and statistics for the SJF scheduler.
// Uses sjf_pkg types and the shared divider sjf_div.
`timescale 1ns / 1ps

module sjf_core import sjf_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      res_valid,
  input  logic      res_ready,
  output out_item_t res_data
);

  localparam int CNT_W = $clog2(MAX_PROCS + 1);
  localparam int IDX_W = $clog2(MAX_PROCS);
  localparam int AW    = (TIME_BITS < IN_TIME_W) ? TIME_BITS : IN_TIME_W;
  localparam int TW    = AW + CNT_W + 1;
  localparam int RAT_W = TW + FRAC_W;
  localparam int SUM_W = RAT_W + CNT_W;
  localparam int DVD_W = SUM_W;
  localparam int DVS_W = (AW > CNT_W) ? AW : CNT_W;
  localparam int XW    = (TW > OUT_TIME_W) ? TW : OUT_TIME_W;
  localparam int YW    = (DVD_W > AVG_W) ? DVD_W : AVG_W;

  typedef enum logic [2:0] {
    S_LOAD, S_SCAN, S_PICK, S_RATIO, S_AVG, S_EMIT
  } state_t;

  state_t state_r;

  logic [AW-1:0]    arr_mem [MAX_PROCS];
  logic [AW-1:0]    bur_mem [MAX_PROCS];
  logic [AW-1:0]    arr_q_r, bur_q_r;
  logic [MAX_PROCS-1:0] flags_r;

  logic [CNT_W-1:0] cnt_r, ra_r, k_r;
  logic             p_vld_r;
  logic [IDX_W-1:0] p_idx_r;
  logic [TW-1:0]    cur_r;

  logic             fa_r, fe_r;
  logic [IDX_W-1:0] fa_idx_r, fe_idx_r;
  logic [AW-1:0]    fa_arr_r, fa_bur_r, fe_arr_r, fe_bur_r;

  logic [AW-1:0]    bur_r;
  logic [TW-1:0]    wait_r, tat_r;
  logic [SUM_W-1:0] sum_wait_r, sum_tat_r, sum_rat_r;
  logic [1:0]       avg_sel_r;
  out_item_t        res_r;

  logic             div_go_r;
  logic [DVD_W-1:0] dvd_r;
  logic [DVS_W-1:0] dvs_r;
  logic             div_done;
  logic [DVD_W-1:0] div_q;

  logic             mem_we;
  logic [IDX_W-1:0] raddr;
  logic             cand, arrived, upd_fa, upd_fe;
  logic [IDX_W-1:0] sel_idx;
  logic [AW-1:0]    sel_arr, sel_bur;
  logic [TW-1:0]    cur_eff, wait_c, tat_c;
  logic [XW-1:0]    start_x, wait_x, tat_x;
  logic [RAT_W-1:0] ratio;
  logic [SUM_W-1:0] sw_nxt, st_nxt, sr_nxt;
  logic [YW-1:0]    q_x;
  logic [AVG_W-1:0] avg_s;
  logic [CNT_W-1:0] k_nxt;

  sjf_div #(.DVD_W(DVD_W), .DVS_W(DVS_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_go_r),
    .dividend (dvd_r),
    .divisor  (dvs_r),
    .done     (div_done),
    .quotient (div_q)
  );

  assign in_ready  = (state_r == S_LOAD);
  assign res_valid = (state_r == S_EMIT);
  assign res_data  = res_r;
  assign mem_we    = in_valid && in_ready && (cnt_r < CNT_W'(MAX_PROCS));
  assign raddr     = ra_r[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      arr_mem[cnt_r[IDX_W-1:0]] <= in_data.arrival_time[AW-1:0];
      bur_mem[cnt_r[IDX_W-1:0]] <= in_data.burst_time[AW-1:0];
    end
    arr_q_r <= arr_mem[raddr];
    bur_q_r <= bur_mem[raddr];
  end

  always_comb begin
    // One scan pass tracks both the best arrived process and, in case none
    // has arrived yet, the shortest among those arriving earliest.
    cand    = p_vld_r && !flags_r[p_idx_r];
    arrived = (TW'(arr_q_r) <= cur_r);
    upd_fa  = cand && arrived && (!fa_r || (bur_q_r < fa_bur_r));
    upd_fe  = cand && (!fe_r || (arr_q_r < fe_arr_r) ||
                       ((arr_q_r == fe_arr_r) && (bur_q_r < fe_bur_r)));

    sel_idx = fa_r ? fa_idx_r : fe_idx_r;
    sel_arr = fa_r ? fa_arr_r : fe_arr_r;
    sel_bur = fa_r ? fa_bur_r : fe_bur_r;
    cur_eff = fa_r ? cur_r : TW'(fe_arr_r);
    wait_c  = cur_eff - TW'(sel_arr);
    tat_c   = wait_c + TW'(sel_bur);
    start_x = XW'(cur_eff);
    wait_x  = XW'(wait_c);
    tat_x   = XW'(tat_c);

    ratio  = (bur_r == '0) ? '0 : div_q[RAT_W-1:0];
    sw_nxt = sum_wait_r + SUM_W'(wait_r);
    st_nxt = sum_tat_r + SUM_W'(tat_r);
    sr_nxt = sum_rat_r + SUM_W'(ratio);
    k_nxt  = k_r + 1'b1;

    q_x   = YW'(div_q);
    avg_s = (q_x > YW'(AVG_MAX)) ? AVG_MAX : q_x[AVG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_LOAD;
      cnt_r      <= '0;
      flags_r    <= '0;
      cur_r      <= '0;
      k_r        <= '0;
      ra_r       <= '0;
      p_vld_r    <= 1'b0;
      fa_r       <= 1'b0;
      fe_r       <= 1'b0;
      div_go_r   <= 1'b0;
      avg_sel_r  <= '0;
      sum_wait_r <= '0;
      sum_tat_r  <= '0;
      sum_rat_r  <= '0;
    end else begin
      div_go_r <= 1'b0;
      unique case (state_r)
        S_LOAD: begin
          if (in_valid) begin
            if (mem_we) cnt_r <= cnt_r + 1'b1;
            if (in_data.is_last) begin
              state_r <= S_SCAN;
              cur_r   <= '0;
              k_r     <= '0;
              ra_r    <= '0;
              p_vld_r <= 1'b0;
              fa_r    <= 1'b0;
              fe_r    <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (ra_r < cnt_r) begin
            ra_r    <= ra_r + 1'b1;
            p_vld_r <= 1'b1;
            p_idx_r <= raddr;
          end else begin
            p_vld_r <= 1'b0;
            if (!p_vld_r) state_r <= S_PICK;
          end
          if (upd_fa) begin
            fa_r     <= 1'b1;
            fa_idx_r <= p_idx_r;
            fa_arr_r <= arr_q_r;
            fa_bur_r <= bur_q_r;
          end
          if (upd_fe) begin
            fe_r     <= 1'b1;
            fe_idx_r <= p_idx_r;
            fe_arr_r <= arr_q_r;
            fe_bur_r <= bur_q_r;
          end
        end
        S_PICK: begin
          flags_r[sel_idx]      <= 1'b1;
          cur_r                 <= cur_eff;
          bur_r                 <= sel_bur;
          wait_r                <= wait_c;
          tat_r                 <= tat_c;
          res_r.process_id      <= ID_W'({1'b0, sel_idx} + 1'b1);
          res_r.start_time      <= (start_x > XW'(TIME_MAX)) ? TIME_MAX
                                                             : start_x[OUT_TIME_W-1:0];
          res_r.wait_time       <= (wait_x > XW'(TIME_MAX)) ? TIME_MAX
                                                            : wait_x[OUT_TIME_W-1:0];
          res_r.turnaround_time <= (tat_x > XW'(TIME_MAX)) ? TIME_MAX
                                                           : tat_x[OUT_TIME_W-1:0];
          res_r.avg_wait        <= '0;
          res_r.avg_turnaround  <= '0;
          res_r.avg_ratio       <= '0;
          res_r.last_result     <= 1'b0;
          div_go_r              <= 1'b1;
          dvd_r                 <= DVD_W'({tat_c, FRAC_W'(0)});
          dvs_r                 <= DVS_W'(sel_bur);
          state_r               <= S_RATIO;
        end
        S_RATIO: begin
          if (div_done) begin
            sum_wait_r <= sw_nxt;
            sum_tat_r  <= st_nxt;
            sum_rat_r  <= sr_nxt;
            cur_r      <= cur_r + TW'(bur_r);
            k_r        <= k_nxt;
            if (k_nxt == cnt_r) begin
              // Last decision: the three averages reuse the divider in turn.
              state_r   <= S_AVG;
              avg_sel_r <= '0;
              div_go_r  <= 1'b1;
              dvd_r     <= sw_nxt << FRAC_W;
              dvs_r     <= DVS_W'(cnt_r);
            end else begin
              state_r <= S_EMIT;
            end
          end
        end
        S_AVG: begin
          if (div_done) begin
            case (avg_sel_r)
              2'd0: begin
                res_r.avg_wait <= avg_s;
                avg_sel_r      <= 2'd1;
                div_go_r       <= 1'b1;
                dvd_r          <= sum_tat_r << FRAC_W;
              end
              2'd1: begin
                res_r.avg_turnaround <= avg_s;
                avg_sel_r            <= 2'd2;
                div_go_r             <= 1'b1;
                dvd_r                <= sum_rat_r;
              end
              default: begin
                res_r.avg_ratio   <= avg_s;
                res_r.last_result <= 1'b1;
                state_r           <= S_EMIT;
              end
            endcase
          end
        end
        S_EMIT: begin
          if (res_ready) begin
            if (res_r.last_result) begin
              state_r    <= S_LOAD;
              cnt_r      <= '0;
              flags_r    <= '0;
              sum_wait_r <= '0;
              sum_tat_r  <= '0;
              sum_rat_r  <= '0;
            end else begin
              state_r <= S_SCAN;
              ra_r    <= '0;
              p_vld_r <= 1'b0;
              fa_r    <= 1'b0;
              fe_r    <= 1'b0;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

endmodule

FILE: hw/rtl/sjf_nonpreemptive_scheduler_top.sv
// Top level of the non-preemptive shortest-job-first scheduler.
// Depends on sjf_pkg, sjf_core and sjf_div.
//
//  Channel   Ports                          Moves
//  input     in_valid, in_ready, in_data    one process (arrival, burst, is_last)
//  result    out_valid, out_ready, out_data one scheduled process, averages on last
//
// Loading takes one item per cycle. After the item with is_last, each decision
// is a scan of the store and a pick, then a division in the shared bit-serial
// divider and the hand-over of the result (DVD_W is 39 bits at the defaults).
// The final result adds three more divisions. Reset is synchronous and clears
// all control state. A stalled result holds in the output register and stalls
// the sequencer.
`timescale 1ns / 1ps

module sjf_nonpreemptive_scheduler_top import sjf_pkg::*; #(
  parameter int MAX_PROCS = MAX_PROCS_DEF,
  parameter int TIME_BITS = TIME_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  logic      res_valid, res_ready;
  out_item_t res_data;
  logic      out_valid_r;
  out_item_t out_data_r;

  sjf_core #(.MAX_PROCS(MAX_PROCS), .TIME_BITS(TIME_BITS)) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_r <= 1'b1;
        out_data_r  <= res_data;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // The sequencer never offers a result while it is still loading.
  a_no_result_in_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && res_valid))
    else $error("result offered during load");

  // Closing the set stops loading on the next cycle.
  a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.is_last) |=> !in_ready)
    else $error("input still taken after last item");

  // Averages are only carried by the final result.
  a_avg_last_only: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.last_result) |->
      (out_data.avg_wait == '0 && out_data.avg_turnaround == '0 &&
       out_data.avg_ratio == '0))
    else $error("averages on a non-final result");

endmodule
